>>> rtl/mopt_pkg.sv
// ---------------------------------------------------------------------------
// Orbit-trap Mandelbrot pixel: shared package
// Widths, constants, the log2 chain record and the register map.
// ---------------------------------------------------------------------------
package mopt_pkg;

  localparam int FRAC_BITS      = 40;
  localparam int MAX_ITER_LIMIT = 64;
  localparam int LOG_FRAC       = 16;

  localparam int U_W    = 16;
  localparam int CFG_W  = 43;
  localparam int ROT_W  = 31;
  localparam int ITER_W = 7;
  localparam int GAIN_W = 6;
  localparam int PAL_W  = 8;

  // c is the centre plus two 16 x 31 products.
  localparam int SPW = U_W + ROT_W;
  localparam int CW  = SPW + 1;
  // z holds a square of at most 2^(FRAC_BITS+6) plus c, with headroom.
  localparam int ZW  = ((FRAC_BITS + 8 > CW) ? FRAC_BITS + 8 : CW) + 3;
  localparam int TW  = ZW - 1;
  // Operands of the multipliers never exceed 8.0 in magnitude.
  localparam int MW  = FRAC_BITS + 4;
  localparam int HW  = (MW + 1) / 2;
  localparam int OPW = 2 * HW;
  localparam int PW  = 2 * OPW;
  localparam int SQW = PW - FRAC_BITS;
  localparam int EXW = $clog2(TW);

  localparam int MANT_W = 31;
  localparam int NEG_W  = $clog2(FRAC_BITS + 1) + 1 + LOG_FRAC;
  localparam int SCL_W  = NEG_W + GAIN_W + 1;

  localparam logic [ZW-1:0]  ESC_MAG    = ZW'(1) << (FRAC_BITS + 3);
  localparam logic [SQW:0]   BOUND      = (SQW + 1)'(1) << (FRAC_BITS + 6);
  localparam logic [TW-1:0]  TRAP_FLOOR =
    TW'(((64'd1 << FRAC_BITS) + 64'd50000) / 64'd100000);

  typedef enum logic [2:0] {
    CFG_CENTER_RE = 3'd0,
    CFG_CENTER_IM = 3'd1,
    CFG_ROT_COS   = 3'd2,
    CFG_ROT_SIN   = 3'd3,
    CFG_MAX_ITER  = 3'd4,
    CFG_GAIN      = 3'd5,
    CFG_SHIFT     = 3'd6
  } cfg_idx_t;

  // One slot of the log2 chain.
  typedef struct packed {
    logic                vld;
    logic [MANT_W-1:0]   mant;
    logic [LOG_FRAC-1:0] frac;
    logic [EXW-1:0]      expo;
  } lchain_t;

  function automatic logic [ZW-1:0] zmag(input logic signed [ZW-1:0] z);
    zmag = z[ZW-1] ? ZW'(-z) : ZW'(z);
  endfunction

endpackage

>>> rtl/mopt_mul.sv
// ---------------------------------------------------------------------------
// Orbit-trap Mandelbrot pixel: unsigned multiplier
// Forms a full product from four half-width partial products, one a cycle.
// ---------------------------------------------------------------------------
module mopt_mul
  import mopt_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [OPW-1:0] a,
  input  logic [OPW-1:0] b,
  output logic           done,
  output logic [PW-1:0]  prod
);

  logic [OPW-1:0]          a_r, b_r;
  logic [PW-1:0]           acc_r, acc_nxt;
  logic [1:0]              step_r;
  logic                    run_r, done_r;
  logic [HW-1:0]           opa, opb;
  logic [OPW-1:0]          pp;
  logic [$clog2(PW)-1:0]   sh;

  always_comb begin
    case (step_r)
      2'd1: begin
        opa = a_r[HW-1:0];
        opb = b_r[OPW-1:HW];
        sh  = ($clog2(PW))'(HW);
      end
      2'd2: begin
        opa = a_r[OPW-1:HW];
        opb = b_r[HW-1:0];
        sh  = ($clog2(PW))'(HW);
      end
      2'd3: begin
        opa = a_r[OPW-1:HW];
        opb = b_r[OPW-1:HW];
        sh  = ($clog2(PW))'(2 * HW);
      end
      default: begin
        opa = a_r[HW-1:0];
        opb = b_r[HW-1:0];
        sh  = '0;
      end
    endcase
    pp      = OPW'(opa) * OPW'(opb);
    acc_nxt = acc_r + (PW'(pp) << sh);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= run_r && (step_r == 2'd3);
      if (start) begin
        run_r  <= 1'b1;
        step_r <= '0;
      end else if (run_r) begin
        step_r <= step_r + 2'd1;
        if (step_r == 2'd3) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (run_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

>>> rtl/mopt_log_cell.sv
// ---------------------------------------------------------------------------
// Orbit-trap Mandelbrot pixel: log2 cell
// Squares the mantissa, renormalises it and appends one fraction bit.
// ---------------------------------------------------------------------------
module mopt_log_cell
  import mopt_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  lchain_t din,
  output lchain_t dout
);

  logic [2*MANT_W-1:0]   sq;
  logic [MANT_W:0]       sq_hi;
  logic                  vld_r;
  logic [MANT_W-1:0]     mant_r;
  logic [LOG_FRAC-1:0]   frac_r;
  logic [EXW-1:0]        expo_r;

  assign sq    = (2 * MANT_W)'(din.mant) * (2 * MANT_W)'(din.mant);
  assign sq_hi = sq[2*MANT_W-1:MANT_W-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= din.vld;
    end
  end

  // A square at or above two gives a one bit and is halved.
  always_ff @(posedge clk) begin
    mant_r <= sq_hi[MANT_W] ? sq_hi[MANT_W:1] : sq_hi[MANT_W-1:0];
    frac_r <= {din.frac[LOG_FRAC-2:0], sq_hi[MANT_W]};
    expo_r <= din.expo;
  end

  always_comb begin
    dout.vld  = vld_r;
    dout.mant = mant_r;
    dout.frac = frac_r;
    dout.expo = expo_r;
  end

endmodule

>>> rtl/mandelbrot_orbit_trap_pixel.sv
// ---------------------------------------------------------------------------
// Orbit-trap Mandelbrot pixel
// Maps a plane position onto c, iterates z = z^2 + c and turns the orbit
// trap of an escaped orbit into a palette index.
// ---------------------------------------------------------------------------
// Usage: a pixel position is offered on the in_ channel (valid/ready) and one
// result transaction per pixel leaves on the out_ channel. One pixel is
// worked on at a time; in_ready is high only while the block is idle.
// Sequence: c is formed from four signed products; each iteration then runs
// three multipliers, each building a product from four partial products, one
// a cycle. An escaped pixel's trap is clamped, normalised by one-bit shifts
// and passed through the chain of 16 log2 cells.
// The result sits in an output register: when the receiver stalls, the block
// still accepts and works on the next pixel, and waits only when that one is
// finished and the register is still full.
// Reset (synchronous, active low) returns the controller to idle, empties the
// output register and loads the configuration reset values. Configuration
// writes take effect at once. The user must make them only while the block
// is idle; the block itself does not enforce this.
// ---------------------------------------------------------------------------
module mandelbrot_orbit_trap_pixel
  import mopt_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [U_W-1:0]   in_plane_u,
  input  logic signed [U_W-1:0]   in_plane_v,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_escaped,
  output logic [PAL_W-1:0]        out_palette_index,
  output logic [ITER_W-1:0]       out_iterations_done,
  input  logic                    cfg_we,
  input  logic [2:0]              cfg_index,
  input  logic [CFG_W-1:0]        cfg_wdata
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SETUP = 9'b000000010,
    S_CHECK = 9'b000000100,
    S_MUL   = 9'b000001000,
    S_STEP  = 9'b000010000,
    S_CLAMP = 9'b000100000,
    S_NORM  = 9'b001000000,
    S_LOG   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic signed [CFG_W-1:0] center_re_r, center_im_r;
  logic signed [ROT_W-1:0] rot_cos_r, rot_sin_r;
  logic [ITER_W-1:0]       max_iter_r;
  logic [GAIN_W-1:0]       gain_r;
  logic [PAL_W-1:0]        shift_r;

  // Working registers of the current pixel.
  logic signed [U_W-1:0]   u_r, v_r;
  logic [1:0]              sc_r;
  logic signed [CW-1:0]    acc_r, cr_r, ci_r;
  logic signed [ZW-1:0]    zr_r, zi_r;
  logic [TW-1:0]           trap_r;
  logic [ITER_W-1:0]       n_r;
  logic                    esc_r;
  logic [TW-1:0]           norm_r;
  logic [EXW-1:0]          expo_r;
  logic signed [SCL_W-1:0] scl_r;

  logic                    out_valid_r, esc_out_r;
  logic [PAL_W-1:0]        pal_out_r;
  logic [ITER_W-1:0]       iter_out_r;

  // Combinational helpers.
  logic signed [U_W-1:0]   sa;
  logic signed [ROT_W-1:0] sb;
  logic signed [SPW-1:0]   sprod;
  logic [ITER_W-1:0]       limit;
  logic [ZW-1:0]           mag_zr, mag_zi, zmin;
  logic [TW-1:0]           trap_upd;
  logic                    big, at_limit, mul_start, mul_done, slot_free;
  logic [PW-1:0]           prod_rr, prod_ii, prod_ri;
  logic                    done_rr, done_ii, done_ri;
  logic [SQW-1:0]          zr2, zi2;
  logic [SQW:0]            sq_sum, xy;
  logic                    esc_hit;
  logic signed [ZW-1:0]    zr_step, zi_step;
  logic signed [NEG_W-1:0] neg;
  logic signed [SCL_W-1:0] scl;
  logic                    rnd;
  logic [PAL_W-1:0]        pal;
  lchain_t                 chain_w [LOG_FRAC+1];

  assign in_ready  = (state_r == S_IDLE);
  assign slot_free = !out_valid_r || out_ready;

  // ------------------------------------------------------------------
  // Configuration port
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_re_r <= '0;
      center_im_r <= '0;
      rot_cos_r   <= '0;
      rot_sin_r   <= '0;
      max_iter_r  <= ITER_W'(40);
      gain_r      <= GAIN_W'(26);
      shift_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CENTER_RE: center_re_r <= cfg_wdata;
        CFG_CENTER_IM: center_im_r <= cfg_wdata;
        CFG_ROT_COS:   rot_cos_r   <= cfg_wdata[ROT_W-1:0];
        CFG_ROT_SIN:   rot_sin_r   <= cfg_wdata[ROT_W-1:0];
        CFG_MAX_ITER:  max_iter_r  <= cfg_wdata[ITER_W-1:0];
        CFG_GAIN:      gain_r      <= cfg_wdata[GAIN_W-1:0];
        CFG_SHIFT:     shift_r     <= cfg_wdata[PAL_W-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Forming c: one signed product a cycle, four products accumulated in all.
  // ------------------------------------------------------------------
  always_comb begin
    case (sc_r)
      2'd1: begin
        sa = v_r;
        sb = rot_sin_r;
      end
      2'd2: begin
        sa = u_r;
        sb = rot_sin_r;
      end
      2'd3: begin
        sa = v_r;
        sb = rot_cos_r;
      end
      default: begin
        sa = u_r;
        sb = rot_cos_r;
      end
    endcase
    sprod = SPW'(sa) * SPW'(sb);
  end

  // ------------------------------------------------------------------
  // Escape test and trap. The trap takes the z left by the previous
  // step, so it is not touched before the first step. A component above
  // 8.0 always squares to more than the bound, which keeps the
  // multiplier operands narrow.
  // ------------------------------------------------------------------
  always_comb begin
    limit    = (max_iter_r > ITER_W'(MAX_ITER_LIMIT)) ? ITER_W'(MAX_ITER_LIMIT)
                                                      : max_iter_r;
    mag_zr   = zmag(zr_r);
    mag_zi   = zmag(zi_r);
    zmin     = (mag_zr < mag_zi) ? mag_zr : mag_zi;
    trap_upd = ((n_r != '0) && (TW'(zmin) < trap_r)) ? TW'(zmin) : trap_r;
    big      = (mag_zr > ESC_MAG) || (mag_zi > ESC_MAG);
    at_limit = (n_r == limit);
    mul_start = (state_r == S_CHECK) && !at_limit && !big;
  end

  mopt_mul u_mul_rr (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (OPW'(mag_zr[MW-1:0])),
    .b     (OPW'(mag_zr[MW-1:0])),
    .done  (done_rr),
    .prod  (prod_rr)
  );

  mopt_mul u_mul_ii (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (OPW'(mag_zi[MW-1:0])),
    .b     (OPW'(mag_zi[MW-1:0])),
    .done  (done_ii),
    .prod  (prod_ii)
  );

  mopt_mul u_mul_ri (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (OPW'(mag_zr[MW-1:0])),
    .b     (OPW'(mag_zi[MW-1:0])),
    .done  (done_ri),
    .prod  (prod_ri)
  );

  assign mul_done = done_rr && done_ii && done_ri;

  // Products are truncated magnitudes; the cross term carries the sign of
  // re*im and is scaled by two through the smaller shift.
  always_comb begin
    zr2     = prod_rr[PW-1:FRAC_BITS];
    zi2     = prod_ii[PW-1:FRAC_BITS];
    xy      = prod_ri[PW-1:FRAC_BITS-1];
    sq_sum  = (SQW + 1)'(zr2) + (SQW + 1)'(zi2);
    esc_hit = (sq_sum > BOUND);
    zr_step = ZW'(zr2) - ZW'(zi2) + ZW'(cr_r);
    zi_step = ((zr_r[ZW-1] ^ zi_r[ZW-1]) ? (ZW'(0) - ZW'(xy)) : ZW'(xy))
              + ZW'(ci_r);
  end

  // ------------------------------------------------------------------
  // log2 of the clamped trap: the exponent comes from the normalising
  // shifts, the 16 fraction bits from the chain of squaring cells.
  // ------------------------------------------------------------------
  assign chain_w[0] = {(state_r == S_NORM) && norm_r[TW-1], norm_r[TW-1 -: MANT_W],
                       {LOG_FRAC{1'b0}}, expo_r};

  for (genvar k = 0; k < LOG_FRAC; k++) begin : g_log
    mopt_log_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .din   (chain_w[k]),
      .dout  (chain_w[k+1])
    );
  end

  // -log2(trap) in Q16 is (FRAC_BITS - exponent) minus the fraction; the
  // index is its product with the gain, truncated toward zero, plus the shift.
  always_comb begin
    neg = (NEG_W'(FRAC_BITS) << LOG_FRAC) - (NEG_W'(chain_w[LOG_FRAC].expo) << LOG_FRAC)
          - NEG_W'(chain_w[LOG_FRAC].frac);
    scl = SCL_W'(neg) * SCL_W'($signed({1'b0, gain_r}));
    rnd = scl_r[SCL_W-1] && (scl_r[LOG_FRAC-1:0] != '0);
    pal = scl_r[LOG_FRAC+PAL_W-1:LOG_FRAC] + PAL_W'(rnd) + shift_r;
  end

  // ------------------------------------------------------------------
  // Sequencer
  // ------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        if (sc_r == 2'd3) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (at_limit) begin
          state_nxt = S_OUT;
        end else if (big) begin
          state_nxt = S_CLAMP;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (mul_done) begin
          state_nxt = S_STEP;
        end
      end
      S_STEP:  state_nxt = esc_hit ? S_CLAMP : S_CHECK;
      S_CLAMP: state_nxt = S_NORM;
      S_NORM: begin
        if (norm_r[TW-1]) begin
          state_nxt = S_LOG;
        end
      end
      S_LOG: begin
        if (chain_w[LOG_FRAC].vld) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == S_OUT) && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        u_r    <= in_plane_u;
        v_r    <= in_plane_v;
        sc_r   <= '0;
        zr_r   <= '0;
        zi_r   <= '0;
        n_r    <= '0;
        trap_r <= '1;
      end
      S_SETUP: begin
        sc_r <= sc_r + 2'd1;
        case (sc_r)
          2'd1:    cr_r  <= acc_r - CW'(sprod);
          2'd2:    acc_r <= CW'(center_im_r) + CW'(sprod);
          2'd3:    ci_r  <= acc_r + CW'(sprod);
          default: acc_r <= CW'(center_re_r) + CW'(sprod);
        endcase
      end
      S_CHECK: begin
        trap_r <= trap_upd;
        esc_r  <= !at_limit && big;
      end
      S_STEP: begin
        if (esc_hit) begin
          esc_r <= 1'b1;
        end else begin
          zr_r <= zr_step;
          zi_r <= zi_step;
          n_r  <= n_r + ITER_W'(1);
        end
      end
      S_CLAMP: begin
        norm_r <= (trap_r < TRAP_FLOOR) ? TRAP_FLOOR : trap_r;
        expo_r <= EXW'(TW - 1);
      end
      S_NORM: begin
        if (!norm_r[TW-1]) begin
          norm_r <= norm_r << 1;
          expo_r <= expo_r - EXW'(1);
        end
      end
      S_LOG: begin
        scl_r <= scl;
      end
      S_OUT: begin
        if (slot_free) begin
          esc_out_r  <= esc_r;
          pal_out_r  <= esc_r ? pal : '0;
          iter_out_r <= n_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid           = out_valid_r;
  assign out_escaped         = esc_out_r;
  assign out_palette_index   = pal_out_r;
  assign out_iterations_done = iter_out_r;

endmodule

>>> sim/tb_mandelbrot_orbit_trap_pixel.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for the orbit-trap Mandelbrot pixel
// Sends pixel positions under a series of zoom, rotation and palette settings.
// Each result is checked against a typed value or a bit-accurate predictor
// of escape-time iteration, orbit trap and fixed-point log2 palette mapping.
// ---------------------------------------------------------------------------
module tb_mandelbrot_orbit_trap_pixel;
  import mopt_pkg::*;

  // Product magnitude cap of the fixed-point multiply in fx_mul.
  localparam logic [127:0] PROD_SAT   = 128'd1 << 61;
  localparam logic [63:0]  TRAP_MIN   = ((64'd1 << FRAC_BITS) + 64'd50000) / 64'd100000;
  // An index with no register behind it; a write to it must be ignored.
  localparam logic [2:0]   CFG_UNUSED = 3'd7;

  typedef struct packed {
    logic              escaped;
    logic [PAL_W-1:0]  pal;
    logic [ITER_W-1:0] iters;
  } pix_res_t;

  typedef struct {
    logic signed [U_W-1:0] u;
    logic signed [U_W-1:0] v;
    logic                  typed;
    pix_res_t              res;
  } pix_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic signed [U_W-1:0] in_plane_u;
  logic signed [U_W-1:0] in_plane_v;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_escaped;
  logic [PAL_W-1:0]      out_palette_index;
  logic [ITER_W-1:0]     out_iterations_done;
  logic                  cfg_we;
  logic [2:0]            cfg_index;
  logic [CFG_W-1:0]      cfg_wdata;

  // Shadow copy of the configuration registers.
  logic [CFG_W-1:0]  sh_cen_re, sh_cen_im;
  logic [ROT_W-1:0]  sh_cos, sh_sin;
  logic [ITER_W-1:0] sh_max_iter;
  logic [GAIN_W-1:0] sh_gain;
  logic [PAL_W-1:0]  sh_shift;

  pix_res_t pending_pixels[$];
  int       mismatches;
  int       pixels_sent;
  int       pixels_seen;
  bit       idling;
  int       stall_left;

  mandelbrot_orbit_trap_pixel u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_plane_u          (in_plane_u),
    .in_plane_v          (in_plane_v),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_escaped         (out_escaped),
    .out_palette_index   (out_palette_index),
    .out_iterations_done (out_iterations_done),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // (a*b) >> s, truncated toward zero, magnitude capped at 2^61.
  function automatic longint fx_mul(input longint a, input longint b, input int s);
    logic [63:0]  ma, mb;
    logic [127:0] prod;
    longint       r;
    ma   = (a < 0) ? 64'(-a) : 64'(a);
    mb   = (b < 0) ? 64'(-b) : 64'(b);
    prod = ({64'd0, ma} * {64'd0, mb}) >> s;
    if (prod > PROD_SAT) prod = PROD_SAT;
    r = longint'(prod[63:0]);
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  // floor(log2(t)) in Q16 by repeated squaring of a Q30 mantissa.
  function automatic longint log2_q16(input logic [63:0] t);
    int          p;
    logic [63:0] m;
    longint      r;
    p = 63;
    while (!t[p] && p > 0) p--;
    m = (p >= 30) ? (t >> (p - 30)) : (t << (30 - p));
    r = longint'(p) << LOG_FRAC;
    for (int i = 0; i < LOG_FRAC; i++) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        r += longint'(1) << (LOG_FRAC - 1 - i);
      end
    end
    return r;
  endfunction

  // Escape-time iteration with orbit trap, under the shadow configuration.
  function automatic pix_res_t orbit_trap_pixel(input logic signed [U_W-1:0] u,
                                                input logic signed [U_W-1:0] v);
    longint      co, si, cr, ci, zr, zi, zr2, zi2, lim, n, neg, idx;
    logic [63:0] trap, a, b, tt;
    pix_res_t    r;
    co   = longint'($signed(sh_cos));
    si   = longint'($signed(sh_sin));
    cr   = longint'($signed(sh_cen_re)) + longint'(u) * co - longint'(v) * si;
    ci   = longint'($signed(sh_cen_im)) + longint'(u) * si + longint'(v) * co;
    zr   = 0;
    zi   = 0;
    trap = '1;
    lim  = (sh_max_iter > MAX_ITER_LIMIT) ? MAX_ITER_LIMIT : longint'(sh_max_iter);
    r    = '0;
    for (n = 0; n < lim; n++) begin
      zr2 = fx_mul(zr, zr, FRAC_BITS);
      zi2 = fx_mul(zi, zi, FRAC_BITS);
      if (zr2 + zi2 > (longint'(64) << FRAC_BITS)) begin
        r.escaped = 1'b1;
        break;
      end
      zi = fx_mul(zr, zi, FRAC_BITS - 1) + ci;
      zr = zr2 - zi2 + cr;
      a  = (zr < 0) ? 64'(-zr) : 64'(zr);
      b  = (zi < 0) ? 64'(-zi) : 64'(zi);
      tt = (a < b) ? a : b;
      if (tt < trap) trap = tt;
    end
    if (r.escaped) begin
      if (trap < TRAP_MIN) trap = TRAP_MIN;
      neg   = (longint'(FRAC_BITS) << LOG_FRAC) - log2_q16(trap);
      idx   = (neg * longint'(sh_gain)) / (longint'(1) << LOG_FRAC);
      r.pal = PAL_W'(idx + longint'(sh_shift));
    end
    r.iters = ITER_W'(n);
    return r;
  endfunction

  task automatic report_mismatch(input string field, input int exp_v, input int got_v);
    $display("[%0t] result %0d: %s expected %0d, got %0d", $time, pixels_seen, field,
             exp_v, got_v);
    mismatches++;
  endtask

  // Register writes are made only with nothing in flight, plus a margin.
  task automatic write_reg(input logic [2:0] idx, input logic [CFG_W-1:0] data);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_CENTER_RE: sh_cen_re   = data;
      CFG_CENTER_IM: sh_cen_im   = data;
      CFG_ROT_COS:   sh_cos      = data[ROT_W-1:0];
      CFG_ROT_SIN:   sh_sin      = data[ROT_W-1:0];
      CFG_MAX_ITER:  sh_max_iter = data[ITER_W-1:0];
      CFG_GAIN:      sh_gain     = data[GAIN_W-1:0];
      CFG_SHIFT:     sh_shift    = data[PAL_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_view(input longint cre, input longint cim, input longint co,
                          input longint si, input int iters, input int gain,
                          input int shift);
    write_reg(CFG_CENTER_RE, CFG_W'(cre));
    write_reg(CFG_CENTER_IM, CFG_W'(cim));
    write_reg(CFG_ROT_COS, CFG_W'(co));
    write_reg(CFG_ROT_SIN, CFG_W'(si));
    write_reg(CFG_MAX_ITER, CFG_W'(iters));
    write_reg(CFG_GAIN, CFG_W'(gain));
    write_reg(CFG_SHIFT, CFG_W'(shift));
  endtask

  // Offers one pixel and holds it until the transaction completes; the
  // expectation is queued at the accepting edge.
  task automatic send_pixel(input logic signed [U_W-1:0] u, input logic signed [U_W-1:0] v,
                            input logic typed, input pix_res_t res);
    int gap;
    if (idling && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_plane_u <= u;
    in_plane_v <= v;
    do @(posedge clk); while (!in_ready);
    pending_pixels.push_back(typed ? res : orbit_trap_pixel(u, v));
    pixels_sent++;
  endtask

  task automatic send_random(input int count, input int span);
    logic signed [U_W-1:0] u, v;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        u = U_W'($urandom);
        v = U_W'($urandom);
      end else begin
        u = U_W'($signed($urandom_range(0, 2 * span)) - span);
        v = U_W'($signed($urandom_range(0, 2 * span)) - span);
      end
      send_pixel(u, v, 1'b0, '0);
    end
    @(posedge clk);
    in_valid <= 1'b0;
  endtask

  // Receiver: random stall bursts and the result check.
  always @(posedge clk) begin
    pix_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        $display("[%0t] result with no pixel outstanding", $time);
        mismatches++;
      end else begin
        want = pending_pixels.pop_front();
        if (out_escaped !== want.escaped)
          report_mismatch("escaped", want.escaped, out_escaped);
        if (out_palette_index !== want.pal)
          report_mismatch("palette_index", want.pal, out_palette_index);
        if (out_iterations_done !== want.iters)
          report_mismatch("iterations_done", want.iters, out_iterations_done);
      end
      pixels_seen++;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (idling && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 7);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Directed rows. The first six run under the reset configuration, where
  // c is always zero: every pixel is interior at the default limit of 40.
  // The rest run under a plain zoom of span about +-2 and are predicted.
  pix_row_t dir_rows[18] = '{
    '{16'sh0000, 16'sh0000, 1'b1, '{1'b0, 8'd0, 7'd40}},
    '{16'sh7FFF, 16'sh7FFF, 1'b1, '{1'b0, 8'd0, 7'd40}},
    '{16'sh8000, 16'sh8000, 1'b1, '{1'b0, 8'd0, 7'd40}},
    '{16'sh7FFF, 16'sh8000, 1'b1, '{1'b0, 8'd0, 7'd40}},
    '{16'sh8000, 16'sh7FFF, 1'b1, '{1'b0, 8'd0, 7'd40}},
    '{16'shAAAA, 16'sh5555, 1'b1, '{1'b0, 8'd0, 7'd40}},
    '{16'sh0000, 16'sh0000, 1'b0, '0},   // origin, interior with zero trap
    '{16'shC000, 16'sh0000, 1'b0, '0},   // c = -1, the orbit alternates between 0 and -1
    '{16'sh4000, 16'sh0000, 1'b0, '0},   // c = 1 on the axis, trap at the floor
    '{16'sh7FFF, 16'sh7FFF, 1'b0, '0},   // far corner, trap above one
    '{16'sh8000, 16'sh8000, 1'b0, '0},
    '{16'sh7FFF, 16'sh8000, 1'b0, '0},
    '{16'sh8000, 16'sh7FFF, 1'b0, '0},
    '{16'sh0000, 16'sh7FFF, 1'b0, '0},
    '{16'sh0000, 16'sh8000, 1'b0, '0},
    '{16'sh0C00, 16'sh3000, 1'b0, '0},   // near the boundary, slow escape
    '{16'shE000, 16'sh2200, 1'b0, '0},
    '{16'sh5555, 16'shAAAA, 1'b0, '0}
  };

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_plane_u  = '0;
    in_plane_v  = '0;
    out_ready   = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_wdata   = '0;
    mismatches  = 0;
    pixels_sent = 0;
    pixels_seen = 0;
    stall_left  = 0;
    idling      = 1'b1;
    sh_cen_re   = '0;
    sh_cen_im   = '0;
    sh_cos      = '0;
    sh_sin      = '0;
    sh_max_iter = 7'd40;
    sh_gain     = 6'd26;
    sh_shift    = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (i == 6) begin
        @(posedge clk);
        in_valid <= 1'b0;
        set_view(0, 0, longint'(1) << 26, 0, 64, 54, 255);
      end
      send_pixel(dir_rows[i].u, dir_rows[i].v, dir_rows[i].typed, dir_rows[i].res);
    end
    @(posedge clk);
    in_valid <= 1'b0;

    // Classic view centred on -0.75, random palette offset.
    set_view(-(longint'(3) << 38), 0, longint'(1) << 26, 0, 64, 26, $urandom_range(0, 255));
    send_random(70, 32767);

    // Rotated view with random centre, limit and gain.
    set_view(longint'($signed($urandom_range(0, 1 << 22))) << 17,
             longint'($signed($urandom_range(0, 1 << 22))) << 16,
             longint'(3) << 24, -(longint'(5) << 23), $urandom_range(12, 64),
             $urandom_range(8, 54), $urandom_range(0, 255));
    write_reg(CFG_UNUSED, '1);
    send_random(70, 32767);

    // Deep zoom near a filament, full limit.
    set_view(-(longint'(817) << 30), longint'(145) << 30, longint'(1) << 18,
             longint'(1) << 16, 64, $urandom_range(8, 54), $urandom_range(0, 255));
    send_random(70, 32767);

    // Register extremes: centre and rotation at their limits, and traps are huge.
    set_view(longint'(4398046511103), -longint'(4398046511104), 1073741823,
             -longint'(1073741824), 12, 8, 255);
    send_random(30, 32767);
    set_view(-longint'(4398046511104), longint'(4398046511103), -longint'(1073741824),
             1073741823, 127, 63, 0);
    send_random(30, 32767);

    // A zero limit runs no pass at all.
    write_reg(CFG_MAX_ITER, 0);
    send_random(15, 32767);

    // Small pixel offsets around the main cardioid, no idling on either side.
    set_view(-(longint'(1) << 39), longint'(1) << 36, longint'(1) << 28,
             longint'(1) << 25, $urandom_range(12, 64), $urandom_range(8, 54),
             $urandom_range(0, 255));
    idling = 1'b0;
    send_random(100, 8192);

    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    $display("Covered %0d pixels (%0d results) over nine register settings,", pixels_sent,
             pixels_seen);
    $display("from reset defaults through deep zoom to saturated and zero-limit views.");
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("mandelbrot_orbit_trap_pixel test passed");
    end else begin
      $display("mandelbrot_orbit_trap_pixel test failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #20000000;
    $display("Timeout with %0d results outstanding", pending_pixels.size());
    $display("mandelbrot_orbit_trap_pixel test failed");
    $finish;
  end

endmodule
